/* design/differential_drive_pid_defines.svh */
// assertion macros shared by the differential drive pid design
`ifndef DIFFERENTIAL_DRIVE_PID_DEFINES_SVH
`define DIFFERENTIAL_DRIVE_PID_DEFINES_SVH

// condition holds at every clock edge outside reset
`define DDPID_ASSERT_HOLDS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

// antecedent implies consequent in the same cycle
`define DDPID_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

/* design/ddpid_pkg.sv */
// types, constants and the helper function of the differential drive pid
`default_nettype none

package ddpid_pkg;

   localparam int SPEED_W  = 16;
   localparam int OFFSET_W = 8;
   localparam int GAIN_W   = 12;
   localparam int DUTY_W   = 10;
   localparam int DRIVE_W  = 11;
   localparam int IDX_W    = 3;
   localparam int CSR_W    = 16;

   localparam int SERR_W  = 17;
   localparam int INTEG_W = 9;
   localparam int ISUM_W  = 18;
   localparam int SDIFF_W = 18;
   localparam int TERR_W  = 17;
   localparam int TDIFF_W = 18;
   localparam int DERIV_W = 4;
   localparam int FILT_W  = 22;

   localparam int SP_W   = 30;
   localparam int SI_W   = 22;
   localparam int SD_W   = 31;
   localparam int TP_W   = 30;
   localparam int TD_W   = 17;
   localparam int SSUM_W = 33;
   localparam int TSUM_W = 31;
   localparam int SOUT_W = 10;
   localparam int TOUT_W = 9;

   localparam int INTEG_LIMIT = 220;
   localparam int SPEED_LIMIT = 500;
   localparam int TURN_LIMIT  = 200;
   localparam int DERIV_DIV   = 10;
   localparam int DERIV_LIMIT = 5;

   localparam logic [IDX_W-1:0] REG_SPEED_TARGET = 3'd0;
   localparam logic [IDX_W-1:0] REG_SPEED_KP     = 3'd1;
   localparam logic [IDX_W-1:0] REG_SPEED_KI     = 3'd2;
   localparam logic [IDX_W-1:0] REG_SPEED_KD     = 3'd3;
   localparam logic [IDX_W-1:0] REG_TURN_TARGET  = 3'd4;
   localparam logic [IDX_W-1:0] REG_TURN_KP      = 3'd5;
   localparam logic [IDX_W-1:0] REG_TURN_KD      = 3'd6;
   localparam logic [IDX_W-1:0] REG_RUN_ENABLE   = 3'd7;

   typedef struct packed {
      logic [SPEED_W-1:0] speed_target;
      logic [GAIN_W-1:0]  speed_kp;
      logic [GAIN_W-1:0]  speed_ki;
      logic [GAIN_W-1:0]  speed_kd;
      logic [SPEED_W-1:0] turn_target;
      logic [GAIN_W-1:0]  turn_kp;
      logic [GAIN_W-1:0]  turn_kd;
      logic               run_enable;
   } cfg_type;

   // loop terms, two's complement
   typedef struct packed {
      logic [SERR_W-1:0]  speed_err;
      logic [INTEG_W-1:0] speed_integ;
      logic [SDIFF_W-1:0] speed_diff;
      logic [TERR_W-1:0]  turn_err;
      logic [DERIV_W-1:0] turn_deriv;
   } errs_type;

   // gain products, two's complement
   typedef struct packed {
      logic [SP_W-1:0] speed_p;
      logic [SI_W-1:0] speed_i;
      logic [SD_W-1:0] speed_d;
      logic [TP_W-1:0] turn_p;
      logic [TD_W-1:0] turn_d;
   } prods_type;

   // trunc((diff*8 + dprev*2)/10) clamped to the derivative limit
   function automatic logic signed [DERIV_W-1:0] deriv_filter(
      input logic signed [TDIFF_W-1:0] diff,
      input logic signed [DERIV_W-1:0] dprev
   );
      logic signed [FILT_W-1:0] x;
      logic [FILT_W-1:0]        mag;
      logic [DERIV_W-1:0]       q;
      x = (FILT_W'(diff) <<< 3) + FILT_W'(dprev) + FILT_W'(dprev);
      mag = x[FILT_W-1] ? FILT_W'(-x) : FILT_W'(x);
      priority if (mag >= FILT_W'(DERIV_DIV * DERIV_LIMIT)) begin
         q = DERIV_W'(DERIV_LIMIT);
      end else if (mag >= FILT_W'(DERIV_DIV * 4)) begin
         q = DERIV_W'(4);
      end else if (mag >= FILT_W'(DERIV_DIV * 3)) begin
         q = DERIV_W'(3);
      end else if (mag >= FILT_W'(DERIV_DIV * 2)) begin
         q = DERIV_W'(2);
      end else if (mag >= FILT_W'(DERIV_DIV)) begin
         q = DERIV_W'(1);
      end else begin
         q = '0;
      end
      return x[FILT_W-1] ? -$signed(q) : $signed(q);
   endfunction

endpackage

`default_nettype wire

/* design/ddpid_ifs.sv */
// request and response channel interfaces
`default_nettype none

interface ddpid_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [ddpid_pkg::SPEED_W-1:0]  left_speed;
   logic signed [ddpid_pkg::SPEED_W-1:0]  right_speed;
   logic signed [ddpid_pkg::OFFSET_W-1:0] line_offset;

   modport source(output valid, output left_speed, output right_speed,
                  output line_offset, input ready);
   modport sink(input valid, input left_speed, input right_speed,
                input line_offset, output ready);
endinterface

interface ddpid_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [ddpid_pkg::DUTY_W-1:0]         left_forward_duty;
   logic [ddpid_pkg::DUTY_W-1:0]         left_reverse_duty;
   logic [ddpid_pkg::DUTY_W-1:0]         right_forward_duty;
   logic [ddpid_pkg::DUTY_W-1:0]         right_reverse_duty;
   logic signed [ddpid_pkg::DRIVE_W-1:0] left_drive;
   logic signed [ddpid_pkg::DRIVE_W-1:0] right_drive;

   modport source(output valid, output left_forward_duty, output left_reverse_duty,
                  output right_forward_duty, output right_reverse_duty,
                  output left_drive, output right_drive, input ready);
   modport sink(input valid, input left_forward_duty, input left_reverse_duty,
                input right_forward_duty, input right_reverse_duty,
                input left_drive, input right_drive, output ready);
endinterface

`default_nettype wire

/* design/ddpid_csr.sv */
// configuration register file
`default_nettype none

module ddpid_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [ddpid_pkg::IDX_W-1:0]   csr_index,
   input  logic [ddpid_pkg::CSR_W-1:0]   csr_wdata,
   output ddpid_pkg::cfg_type            cfg
);

   ddpid_pkg::cfg_type cfg_ff;
   ddpid_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            ddpid_pkg::REG_SPEED_TARGET: cfg_in.speed_target = csr_wdata;
            ddpid_pkg::REG_SPEED_KP:     cfg_in.speed_kp = csr_wdata[ddpid_pkg::GAIN_W-1:0];
            ddpid_pkg::REG_SPEED_KI:     cfg_in.speed_ki = csr_wdata[ddpid_pkg::GAIN_W-1:0];
            ddpid_pkg::REG_SPEED_KD:     cfg_in.speed_kd = csr_wdata[ddpid_pkg::GAIN_W-1:0];
            ddpid_pkg::REG_TURN_TARGET:  cfg_in.turn_target = csr_wdata;
            ddpid_pkg::REG_TURN_KP:      cfg_in.turn_kp = csr_wdata[ddpid_pkg::GAIN_W-1:0];
            ddpid_pkg::REG_TURN_KD:      cfg_in.turn_kd = csr_wdata[ddpid_pkg::GAIN_W-1:0];
            ddpid_pkg::REG_RUN_ENABLE:   cfg_in.run_enable = csr_wdata[0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

/* design/ddpid_err.sv */
// input register, loop errors and loop state update
`default_nettype none
`include "differential_drive_pid_defines.svh"

module ddpid_err (
   input  logic                  clock,
   input  logic                  reset,
   input  ddpid_pkg::cfg_type    cfg,
   ddpid_req_if.sink             req_ch,
   output logic                  out_valid,
   input  logic                  out_ready,
   output ddpid_pkg::errs_type   errs
);

   logic                                  in_v_ff;
   logic signed [ddpid_pkg::SPEED_W-1:0]  ls_ff;
   logic signed [ddpid_pkg::SPEED_W-1:0]  rs_ff;
   logic signed [ddpid_pkg::OFFSET_W-1:0] off_ff;

   logic                                 err_v_ff;
   ddpid_pkg::errs_type                  errs_ff;

   logic signed [ddpid_pkg::INTEG_W-1:0] integ_ff;
   logic signed [ddpid_pkg::SERR_W-1:0]  sprev_ff;
   logic signed [ddpid_pkg::TERR_W-1:0]  tprev_ff;
   logic signed [ddpid_pkg::DERIV_W-1:0] deriv_ff;

   logic                                 err_ready;
   logic                                 move;
   logic signed [ddpid_pkg::SPEED_W:0]   wsum;
   logic signed [ddpid_pkg::SPEED_W-1:0] avg;
   logic signed [ddpid_pkg::SERR_W-1:0]  serr;
   logic signed [ddpid_pkg::ISUM_W-1:0]  isum;
   logic signed [ddpid_pkg::INTEG_W-1:0] integ_in;
   logic signed [ddpid_pkg::SDIFF_W-1:0] sdiff;
   logic signed [ddpid_pkg::TERR_W-1:0]  terr;
   logic signed [ddpid_pkg::TDIFF_W-1:0] tdiff;
   logic signed [ddpid_pkg::DERIV_W-1:0] deriv_in;

   assign err_ready    = !err_v_ff || out_ready;
   assign req_ch.ready = !in_v_ff || err_ready;
   assign move         = in_v_ff && err_ready;

   // speed loop
   assign wsum = (ddpid_pkg::SPEED_W+1)'(ls_ff) + (ddpid_pkg::SPEED_W+1)'(rs_ff);
   assign avg  = wsum[ddpid_pkg::SPEED_W:1];
   assign serr = ddpid_pkg::SERR_W'(avg)
               - ddpid_pkg::SERR_W'($signed(cfg.speed_target));
   assign isum = ddpid_pkg::ISUM_W'(integ_ff) + ddpid_pkg::ISUM_W'(serr);
   assign sdiff = ddpid_pkg::SDIFF_W'(sprev_ff) - ddpid_pkg::SDIFF_W'(serr);

   always_comb begin
      priority if (isum > ddpid_pkg::INTEG_LIMIT) begin
         integ_in = ddpid_pkg::INTEG_W'(ddpid_pkg::INTEG_LIMIT);
      end else if (isum < -ddpid_pkg::INTEG_LIMIT) begin
         integ_in = ddpid_pkg::INTEG_W'(-ddpid_pkg::INTEG_LIMIT);
      end else begin
         integ_in = isum[ddpid_pkg::INTEG_W-1:0];
      end
   end

   // steering loop
   assign terr = ddpid_pkg::TERR_W'(off_ff)
               - ddpid_pkg::TERR_W'($signed(cfg.turn_target));
   assign tdiff = ddpid_pkg::TDIFF_W'(tprev_ff) - ddpid_pkg::TDIFF_W'(terr);
   assign deriv_in = ddpid_pkg::deriv_filter(tdiff, deriv_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff  <= 1'b0;
         err_v_ff <= 1'b0;
         integ_ff <= '0;
         sprev_ff <= '0;
         tprev_ff <= '0;
         deriv_ff <= '0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            in_v_ff <= 1'b1;
         end else if (move) begin
            in_v_ff <= 1'b0;
         end
         if (move) begin
            err_v_ff <= 1'b1;
            integ_ff <= integ_in;
            sprev_ff <= serr;
            tprev_ff <= terr;
            deriv_ff <= deriv_in;
         end else if (out_ready) begin
            err_v_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         ls_ff  <= req_ch.left_speed;
         rs_ff  <= req_ch.right_speed;
         off_ff <= req_ch.line_offset;
      end
      if (move) begin
         errs_ff.speed_err   <= serr;
         errs_ff.speed_integ <= integ_in;
         errs_ff.speed_diff  <= sdiff;
         errs_ff.turn_err    <= terr;
         errs_ff.turn_deriv  <= deriv_in;
      end
   end

   assign out_valid = err_v_ff;
   assign errs      = errs_ff;

   `DDPID_ASSERT_HOLDS(a_integ_bound, clock, reset, integ_ff <= ddpid_pkg::INTEG_LIMIT && integ_ff >= -ddpid_pkg::INTEG_LIMIT, "speed integral outside its clamp")
   `DDPID_ASSERT_HOLDS(a_deriv_bound, clock, reset, deriv_ff <= ddpid_pkg::DERIV_LIMIT && deriv_ff >= -ddpid_pkg::DERIV_LIMIT, "steering derivative outside its clamp")

endmodule

`default_nettype wire

/* design/ddpid_mul.sv */
// gain multiplier stage
`default_nettype none

module ddpid_mul (
   input  logic                  clock,
   input  logic                  reset,
   input  ddpid_pkg::cfg_type    cfg,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  ddpid_pkg::errs_type   errs,
   output logic                  out_valid,
   input  logic                  out_ready,
   output ddpid_pkg::prods_type  prods
);

   logic                 v_ff;
   ddpid_pkg::prods_type prods_ff;
   logic                 move;

   logic signed [ddpid_pkg::SP_W-1:0] sp;
   logic signed [ddpid_pkg::SI_W-1:0] si;
   logic signed [ddpid_pkg::SD_W-1:0] sd;
   logic signed [ddpid_pkg::TP_W-1:0] tp;
   logic signed [ddpid_pkg::TD_W-1:0] td;

   assign in_ready = !v_ff || out_ready;
   assign move     = in_valid && in_ready;

   assign sp = ddpid_pkg::SP_W'($signed({1'b0, cfg.speed_kp}))
             * ddpid_pkg::SP_W'($signed(errs.speed_err));
   assign si = ddpid_pkg::SI_W'($signed({1'b0, cfg.speed_ki}))
             * ddpid_pkg::SI_W'($signed(errs.speed_integ));
   assign sd = ddpid_pkg::SD_W'($signed({1'b0, cfg.speed_kd}))
             * ddpid_pkg::SD_W'($signed(errs.speed_diff));
   assign tp = ddpid_pkg::TP_W'($signed({1'b0, cfg.turn_kp}))
             * ddpid_pkg::TP_W'($signed(errs.turn_err));
   assign td = ddpid_pkg::TD_W'($signed({1'b0, cfg.turn_kd}))
             * ddpid_pkg::TD_W'($signed(errs.turn_deriv));

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (move) begin
         v_ff <= 1'b1;
      end else if (out_ready) begin
         v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         prods_ff.speed_p <= sp;
         prods_ff.speed_i <= si;
         prods_ff.speed_d <= sd;
         prods_ff.turn_p  <= tp;
         prods_ff.turn_d  <= td;
      end
   end

   assign out_valid = v_ff;
   assign prods     = prods_ff;

endmodule

`default_nettype wire

/* design/ddpid_mix.sv */
// output limits, drive mixing, duty split and result register
`default_nettype none
`include "differential_drive_pid_defines.svh"

module ddpid_mix (
   input  logic                  clock,
   input  logic                  reset,
   input  ddpid_pkg::cfg_type    cfg,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  ddpid_pkg::prods_type  prods,
   ddpid_rsp_if.source           rsp_ch
);

   logic                                 v_ff;
   logic [ddpid_pkg::DUTY_W-1:0]         lfwd_ff;
   logic [ddpid_pkg::DUTY_W-1:0]         lrev_ff;
   logic [ddpid_pkg::DUTY_W-1:0]         rfwd_ff;
   logic [ddpid_pkg::DUTY_W-1:0]         rrev_ff;
   logic signed [ddpid_pkg::DRIVE_W-1:0] ld_ff;
   logic signed [ddpid_pkg::DRIVE_W-1:0] rd_ff;

   logic                                 move;
   logic signed [ddpid_pkg::SSUM_W-1:0]  ssum;
   logic signed [ddpid_pkg::TSUM_W-1:0]  tsum;
   logic signed [ddpid_pkg::SOUT_W-1:0]  sout;
   logic signed [ddpid_pkg::TOUT_W-1:0]  tout;
   logic signed [ddpid_pkg::DRIVE_W-1:0] ld;
   logic signed [ddpid_pkg::DRIVE_W-1:0] rd;
   logic signed [ddpid_pkg::DRIVE_W-1:0] ld_neg;
   logic signed [ddpid_pkg::DRIVE_W-1:0] rd_neg;
   logic [ddpid_pkg::DUTY_W-1:0]         lfwd_in;
   logic [ddpid_pkg::DUTY_W-1:0]         lrev_in;
   logic [ddpid_pkg::DUTY_W-1:0]         rfwd_in;
   logic [ddpid_pkg::DUTY_W-1:0]         rrev_in;

   assign in_ready = !v_ff || rsp_ch.ready;
   assign move     = in_valid && in_ready;

   assign ssum = ddpid_pkg::SSUM_W'($signed(prods.speed_p))
               + ddpid_pkg::SSUM_W'($signed(prods.speed_i))
               + ddpid_pkg::SSUM_W'($signed(prods.speed_d));
   assign tsum = ddpid_pkg::TSUM_W'($signed(prods.turn_p))
               + ddpid_pkg::TSUM_W'($signed(prods.turn_d));

   always_comb begin
      priority if (ssum > ddpid_pkg::SPEED_LIMIT) begin
         sout = ddpid_pkg::SOUT_W'(ddpid_pkg::SPEED_LIMIT);
      end else if (ssum < -ddpid_pkg::SPEED_LIMIT) begin
         sout = ddpid_pkg::SOUT_W'(-ddpid_pkg::SPEED_LIMIT);
      end else begin
         sout = ssum[ddpid_pkg::SOUT_W-1:0];
      end
      priority if (tsum > ddpid_pkg::TURN_LIMIT) begin
         tout = ddpid_pkg::TOUT_W'(ddpid_pkg::TURN_LIMIT);
      end else if (tsum < -ddpid_pkg::TURN_LIMIT) begin
         tout = ddpid_pkg::TOUT_W'(-ddpid_pkg::TURN_LIMIT);
      end else begin
         tout = tsum[ddpid_pkg::TOUT_W-1:0];
      end
   end

   assign ld = ddpid_pkg::DRIVE_W'(sout) - ddpid_pkg::DRIVE_W'(tout);
   assign rd = ddpid_pkg::DRIVE_W'(sout) + ddpid_pkg::DRIVE_W'(tout);
   assign ld_neg = -ld;
   assign rd_neg = -rd;

   // sign split, gated by run enable
   always_comb begin
      lfwd_in = '0;
      lrev_in = '0;
      rfwd_in = '0;
      rrev_in = '0;
      if (cfg.run_enable) begin
         if (ld > 0) begin
            lfwd_in = ld[ddpid_pkg::DUTY_W-1:0];
         end else begin
            lrev_in = ld_neg[ddpid_pkg::DUTY_W-1:0];
         end
         if (rd > 0) begin
            rfwd_in = rd[ddpid_pkg::DUTY_W-1:0];
         end else begin
            rrev_in = rd_neg[ddpid_pkg::DUTY_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (move) begin
         v_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         lfwd_ff <= lfwd_in;
         lrev_ff <= lrev_in;
         rfwd_ff <= rfwd_in;
         rrev_ff <= rrev_in;
         ld_ff   <= ld;
         rd_ff   <= rd;
      end
   end

   assign rsp_ch.valid              = v_ff;
   assign rsp_ch.left_forward_duty  = lfwd_ff;
   assign rsp_ch.left_reverse_duty  = lrev_ff;
   assign rsp_ch.right_forward_duty = rfwd_ff;
   assign rsp_ch.right_reverse_duty = rrev_ff;
   assign rsp_ch.left_drive         = ld_ff;
   assign rsp_ch.right_drive        = rd_ff;

   `DDPID_ASSERT_IMPLIES(a_left_fwd_sign, clock, reset, v_ff && ld_ff <= 0, lfwd_ff == '0, "left forward duty with non-positive drive")
   `DDPID_ASSERT_IMPLIES(a_left_rev_sign, clock, reset, v_ff && ld_ff >= 0, lrev_ff == '0, "left reverse duty with non-negative drive")
   `DDPID_ASSERT_IMPLIES(a_right_fwd_sign, clock, reset, v_ff && rd_ff <= 0, rfwd_ff == '0, "right forward duty with non-positive drive")

endmodule

`default_nettype wire

/* design/differential_drive_pid.sv */
// differential drive pid controller, top level
//
// req_ch carries one control tick per transaction: both wheel speeds and the
// centerline offset. rsp_ch returns one transaction per tick with the four
// pwm duties and the signed left and right drives. both channels use a
// valid/ready handshake. the csr port writes one register per clock while
// csr_we is high; the user must write it only while no transaction is in
// flight; the block does not enforce this. a request passes the input
// register, error and state update, gain products and output register.
// throughput: one transaction per cycle while rsp_ch does not stall; the
// speed integral, previous errors and filtered derivative update in the
// error stage. reset clears the configuration registers, the loop state
// and all pipeline valids. when rsp_ch stalls, results hold in the output
// register and up to four transactions are held before req_ch.ready drops.
`default_nettype none

module differential_drive_pid (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [ddpid_pkg::IDX_W-1:0] csr_index,
   input  logic [ddpid_pkg::CSR_W-1:0] csr_wdata,
   ddpid_req_if.sink                   req_ch,
   ddpid_rsp_if.source                 rsp_ch
);

   ddpid_pkg::cfg_type   cfg;
   ddpid_pkg::errs_type  errs;
   ddpid_pkg::prods_type prods;
   logic                 err_valid;
   logic                 err_ready;
   logic                 mul_valid;
   logic                 mul_ready;

   ddpid_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ddpid_err u_err (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_ch    (req_ch),
      .out_valid (err_valid),
      .out_ready (err_ready),
      .errs      (errs)
   );

   ddpid_mul u_mul (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (err_valid),
      .in_ready  (err_ready),
      .errs      (errs),
      .out_valid (mul_valid),
      .out_ready (mul_ready),
      .prods     (prods)
   );

   ddpid_mix u_mix (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .in_valid (mul_valid),
      .in_ready (mul_ready),
      .prods    (prods),
      .rsp_ch   (rsp_ch)
   );

endmodule

`default_nettype wire

/* sim/testbench.sv */
`timescale 1ns / 100ps
// self-checking testbench for the differential drive pid controller
module testbench;

   localparam int RESULT_LATENCY = 4;
   localparam int HOLD_CYCLES    = 120;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_TICKS    = 50;

   typedef struct packed {
      logic signed [ddpid_pkg::SPEED_W-1:0]  left_speed;
      logic signed [ddpid_pkg::SPEED_W-1:0]  right_speed;
      logic signed [ddpid_pkg::OFFSET_W-1:0] line_offset;
   } tick_type;

   typedef struct packed {
      logic [ddpid_pkg::DUTY_W-1:0]         left_forward_duty;
      logic [ddpid_pkg::DUTY_W-1:0]         left_reverse_duty;
      logic [ddpid_pkg::DUTY_W-1:0]         right_forward_duty;
      logic [ddpid_pkg::DUTY_W-1:0]         right_reverse_duty;
      logic signed [ddpid_pkg::DRIVE_W-1:0] left_drive;
      logic signed [ddpid_pkg::DRIVE_W-1:0] right_drive;
   } drive_type;

   class drive_scoreboard;
      ddpid_pkg::cfg_type                   cfg;
      logic signed [ddpid_pkg::INTEG_W-1:0] speed_integ;
      logic signed [ddpid_pkg::SDIFF_W-1:0] speed_prev;
      logic signed [ddpid_pkg::TDIFF_W-1:0] turn_prev;
      logic signed [ddpid_pkg::DERIV_W-1:0] turn_deriv;
      drive_type                            expected_drives[$];
      int                                   errors;
      int                                   ticks;
      int                                   checked;

      function new();
         cfg = '0;
         speed_integ = '0;
         speed_prev = '0;
         turn_prev = '0;
         turn_deriv = '0;
         errors = 0;
         ticks = 0;
         checked = 0;
      endfunction

      function int pending();
         return expected_drives.size();
      endfunction

      function void write_reg(logic [ddpid_pkg::IDX_W-1:0] idx,
                              logic [ddpid_pkg::CSR_W-1:0] data);
         case (idx)
            ddpid_pkg::REG_SPEED_TARGET: cfg.speed_target = data;
            ddpid_pkg::REG_SPEED_KP:     cfg.speed_kp = data[ddpid_pkg::GAIN_W-1:0];
            ddpid_pkg::REG_SPEED_KI:     cfg.speed_ki = data[ddpid_pkg::GAIN_W-1:0];
            ddpid_pkg::REG_SPEED_KD:     cfg.speed_kd = data[ddpid_pkg::GAIN_W-1:0];
            ddpid_pkg::REG_TURN_TARGET:  cfg.turn_target = data;
            ddpid_pkg::REG_TURN_KP:      cfg.turn_kp = data[ddpid_pkg::GAIN_W-1:0];
            ddpid_pkg::REG_TURN_KD:      cfg.turn_kd = data[ddpid_pkg::GAIN_W-1:0];
            ddpid_pkg::REG_RUN_ENABLE:   cfg.run_enable = data[0];
            default: ;
         endcase
      endfunction

      static function longint clamp_mag(longint v, longint lim);
         if (v > lim) return lim;
         if (v < -lim) return -lim;
         return v;
      endfunction

      function void note_tick(tick_type t);
         longint err, speed_out, turn_out, d, ld, rd;
         drive_type r;
         // speed loop
         err = ((longint'($signed(t.left_speed)) + longint'($signed(t.right_speed))) >>> 1)
               - longint'($signed(cfg.speed_target));
         speed_integ = ddpid_pkg::INTEG_W'(clamp_mag(longint'(speed_integ) + err,
                                                     ddpid_pkg::INTEG_LIMIT));
         speed_out = clamp_mag(longint'(cfg.speed_kp) * err
                               + longint'(cfg.speed_ki) * longint'(speed_integ)
                               + longint'(cfg.speed_kd) * (longint'(speed_prev) - err),
                               ddpid_pkg::SPEED_LIMIT);
         speed_prev = ddpid_pkg::SDIFF_W'(err);
         // steering loop
         err = longint'($signed(t.line_offset)) - longint'($signed(cfg.turn_target));
         d = ((longint'(turn_prev) - err) * 8 + longint'(turn_deriv) * 2)
             / ddpid_pkg::DERIV_DIV;
         d = clamp_mag(d, ddpid_pkg::DERIV_LIMIT);
         turn_deriv = ddpid_pkg::DERIV_W'(d);
         turn_out = clamp_mag(longint'(cfg.turn_kp) * err + longint'(cfg.turn_kd) * d,
                              ddpid_pkg::TURN_LIMIT);
         turn_prev = ddpid_pkg::TDIFF_W'(err);
         ld = speed_out - turn_out;
         rd = speed_out + turn_out;
         r = '0;
         if (cfg.run_enable) begin
            if (ld > 0) r.left_forward_duty = ddpid_pkg::DUTY_W'(ld);
            else r.left_reverse_duty = ddpid_pkg::DUTY_W'(-ld);
            if (rd > 0) r.right_forward_duty = ddpid_pkg::DUTY_W'(rd);
            else r.right_reverse_duty = ddpid_pkg::DUTY_W'(-rd);
         end
         r.left_drive = ddpid_pkg::DRIVE_W'(ld);
         r.right_drive = ddpid_pkg::DRIVE_W'(rd);
         expected_drives.push_back(r);
         ticks++;
      endfunction

      function void compare_field(string name, longint want, longint got);
         if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_drive(drive_type got);
         drive_type want;
         if (expected_drives.size() == 0) begin
            $error("drive transaction with no pending tick");
            errors++;
            return;
         end
         want = expected_drives.pop_front();
         checked++;
         compare_field("left_forward_duty", want.left_forward_duty, got.left_forward_duty);
         compare_field("left_reverse_duty", want.left_reverse_duty, got.left_reverse_duty);
         compare_field("right_forward_duty", want.right_forward_duty,
                       got.right_forward_duty);
         compare_field("right_reverse_duty", want.right_reverse_duty,
                       got.right_reverse_duty);
         compare_field("left_drive", want.left_drive, got.left_drive);
         compare_field("right_drive", want.right_drive, got.right_drive);
      endfunction
   endclass

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          csr_we;
   logic [ddpid_pkg::IDX_W-1:0]   csr_index;
   logic [ddpid_pkg::CSR_W-1:0]   csr_wdata;
   ddpid_req_if                   req_ch();
   ddpid_rsp_if                   rsp_ch();

   drive_scoreboard   sb = new();
   int                send_idle_pct;
   int                rsp_idle_pct;
   int                hold_requests = 0;
   int                settings_used = 0;

   differential_drive_pid DUT (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("testbench: FAIL");
      $finish;
   end

   // response side: random stalls plus long hold-offs on request
   initial begin
      int stall_left;
      int holds_done;
      stall_left = 0;
      holds_done = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (holds_done != hold_requests) begin
            holds_done = hold_requests;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_drive(drive_type'{rsp_ch.left_forward_duty, rsp_ch.left_reverse_duty,
                                    rsp_ch.right_forward_duty, rsp_ch.right_reverse_duty,
                                    rsp_ch.left_drive, rsp_ch.right_drive});
   end

   function automatic tick_type tick_of(int l, int r, int o);
      tick_type t;
      t.left_speed = ddpid_pkg::SPEED_W'(l);
      t.right_speed = ddpid_pkg::SPEED_W'(r);
      t.line_offset = ddpid_pkg::OFFSET_W'(o);
      return t;
   endfunction

   function automatic ddpid_pkg::cfg_type random_config(bit wide);
      ddpid_pkg::cfg_type c;
      c.speed_target = wide ? ddpid_pkg::SPEED_W'($urandom)
                            : ddpid_pkg::SPEED_W'($urandom_range(0, 400) - 200);
      c.turn_target  = wide ? ddpid_pkg::SPEED_W'($urandom)
                            : ddpid_pkg::SPEED_W'($urandom_range(0, 60) - 30);
      c.speed_kp = wide ? ddpid_pkg::GAIN_W'($urandom)
                        : ddpid_pkg::GAIN_W'($urandom_range(0, 12));
      c.speed_ki = wide ? ddpid_pkg::GAIN_W'($urandom)
                        : ddpid_pkg::GAIN_W'($urandom_range(0, 6));
      c.speed_kd = wide ? ddpid_pkg::GAIN_W'($urandom)
                        : ddpid_pkg::GAIN_W'($urandom_range(0, 12));
      c.turn_kp  = wide ? ddpid_pkg::GAIN_W'($urandom)
                        : ddpid_pkg::GAIN_W'($urandom_range(0, 12));
      c.turn_kd  = wide ? ddpid_pkg::GAIN_W'($urandom)
                        : ddpid_pkg::GAIN_W'($urandom_range(0, 40));
      c.run_enable = ($urandom_range(0, 3) != 0);
      return c;
   endfunction

   // mostly near the setpoints so the loops stay out of saturation
   function automatic tick_type random_tick(ddpid_pkg::cfg_type c);
      tick_type t;
      if ($urandom_range(0, 99) < 20) begin
         t.left_speed = ddpid_pkg::SPEED_W'($urandom);
         t.right_speed = ddpid_pkg::SPEED_W'($urandom);
         t.line_offset = ddpid_pkg::OFFSET_W'($urandom);
      end else begin
         t.left_speed  = ddpid_pkg::SPEED_W'(c.speed_target + $urandom_range(0, 600) - 300);
         t.right_speed = ddpid_pkg::SPEED_W'(c.speed_target + $urandom_range(0, 600) - 300);
         t.line_offset = ddpid_pkg::OFFSET_W'(c.turn_target + $urandom_range(0, 40) - 20);
      end
      return t;
   endfunction

   task automatic write_reg(logic [ddpid_pkg::IDX_W-1:0] idx,
                            logic [ddpid_pkg::CSR_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.write_reg(idx, data);
   endtask

   // upper bits of narrow registers carry noise
   task automatic load_config(ddpid_pkg::cfg_type c);
      write_reg(ddpid_pkg::REG_SPEED_TARGET, c.speed_target);
      write_reg(ddpid_pkg::REG_SPEED_KP, {4'($urandom), c.speed_kp});
      write_reg(ddpid_pkg::REG_SPEED_KI, {4'($urandom), c.speed_ki});
      write_reg(ddpid_pkg::REG_SPEED_KD, {4'($urandom), c.speed_kd});
      write_reg(ddpid_pkg::REG_TURN_TARGET, c.turn_target);
      write_reg(ddpid_pkg::REG_TURN_KP, {4'($urandom), c.turn_kp});
      write_reg(ddpid_pkg::REG_TURN_KD, {4'($urandom), c.turn_kd});
      write_reg(ddpid_pkg::REG_RUN_ENABLE, {15'($urandom), c.run_enable});
      csr_we <= 1'b0;
      @(posedge clock);
      settings_used++;
   endtask

   task automatic send_tick(tick_type t);
      while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.left_speed <= t.left_speed;
      req_ch.right_speed <= t.right_speed;
      req_ch.line_offset <= t.line_offset;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.note_tick(t);
   endtask

   task automatic wait_for_results();
      req_ch.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (RESULT_LATENCY + 2) @(posedge clock);
   endtask

   initial begin
      ddpid_pkg::cfg_type c;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.left_speed = '0;
      req_ch.right_speed = '0;
      req_ch.line_offset = '0;
      send_idle_pct = 21;
      rsp_idle_pct = 63;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // field extremes and rounding of the speed average
      c = '0;
      c.speed_kp = 2;
      c.speed_ki = 1;
      c.speed_kd = 3;
      c.turn_kp = 5;
      c.turn_kd = 7;
      c.run_enable = 1'b1;
      load_config(c);
      send_tick(tick_of(0, 0, 0));
      send_tick(tick_of(32767, 32767, 127));
      send_tick(tick_of(-32768, -32768, -128));
      send_tick(tick_of(32767, -32768, 0));
      send_tick(tick_of(-1, 0, 1));
      send_tick(tick_of(1, 0, -1));
      send_tick(tick_of(-3, 0, 127));
      send_tick(tick_of(100, 100, -128));
      send_tick(tick_of(-100, -100, 10));
      wait_for_results();

      // largest gains and setpoints, saturation in both directions
      c.speed_target = 16'h7fff;
      c.turn_target = 16'h8000;
      c.speed_kp = '1;
      c.speed_ki = '1;
      c.speed_kd = '1;
      c.turn_kp = '1;
      c.turn_kd = '1;
      load_config(c);
      send_tick(tick_of(-32768, -32768, -128));
      send_tick(tick_of(32767, 32767, 127));
      send_tick(tick_of(0, 0, -128));
      wait_for_results();
      c.speed_target = 16'h8000;
      c.turn_target = 16'h7fff;
      load_config(c);
      send_tick(tick_of(32767, 32767, 127));
      send_tick(tick_of(-32768, -32768, -128));
      wait_for_results();

      // disabled: duties forced to zero, drives still reported
      c = '0;
      c.speed_kp = 1;
      c.turn_kp = 2;
      c.turn_kd = 9;
      load_config(c);
      send_tick(tick_of(200, 200, 50));
      send_tick(tick_of(-200, -200, -50));
      send_tick(tick_of(0, 0, 0));
      wait_for_results();

      // zero drive with all gains cleared
      c = '0;
      c.run_enable = 1'b1;
      load_config(c);
      send_tick(tick_of(1000, -5, 9));
      send_tick(tick_of(-7, 3, -60));
      wait_for_results();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p < 3) begin
            send_idle_pct = 21;
            rsp_idle_pct = 63;
         end else if (p < 6) begin
            send_idle_pct = 63;
            rsp_idle_pct = 21;
         end else begin
            send_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         c = random_config(p == 1 || p == 5);
         load_config(c);
         for (int n = 0; n < PHASE_TICKS; n++) begin
            if (p == 3 && n == 0) begin
               hold_requests++;
               send_idle_pct = 0;
            end
            if (p == 3 && n == 30) begin
               send_idle_pct = 63;
               wait_for_results();
            end
            send_tick(random_tick(c));
         end
         wait_for_results();
      end

      $display("covered %0d control ticks under %0d register settings", sb.ticks,
               settings_used);
      $display("checked %0d drive transactions, %0d mismatches", sb.checked, sb.errors);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end
endmodule
